### hdl/olb_pkg.sv
// shared widths, codes, characters and state encoding for the line log buffer
`default_nettype none

package olb_pkg;

  localparam int unsigned RING_BYTES_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 32;
  localparam int LIMIT_W  = 16;
  localparam int OFFSET_W = 10;
  localparam int LEN_W    = 11;

  // decimal conversion of the tick count
  localparam int DIGITS    = 10;
  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = DIGITS * DIGIT_W;
  localparam int BIT_CNT_W = $clog2(TICK_W);
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 2'd0,
    OP_PREFIX  = 2'd1,
    OP_MEASURE = 2'd2,
    OP_FETCH   = 2'd3
  } op_t;

  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_CLOSE,
    ST_SPACE,
    ST_SCAN,
    ST_RESP
  } st_t;

endpackage

`default_nettype wire

### hdl/olb_in_if.sv
// request channel of the line log buffer
`default_nettype none

interface olb_in_if;
  logic                           valid;
  logic                           ready;
  logic [olb_pkg::OP_W-1:0]       operation;
  logic [olb_pkg::BYTE_W-1:0]     data_byte;
  logic [olb_pkg::TICK_W-1:0]     tick_count;
  logic [olb_pkg::LIMIT_W-1:0]    read_limit;
  logic [olb_pkg::OFFSET_W-1:0]   byte_offset;

  modport source(output valid, operation, data_byte, tick_count, read_limit, byte_offset,
                 input ready);
  modport sink(input valid, operation, data_byte, tick_count, read_limit, byte_offset,
               output ready);
endinterface

`default_nettype wire

### hdl/olb_out_if.sv
// answer channel of the line log buffer
`default_nettype none

interface olb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         answer_kind;
  logic [olb_pkg::LEN_W-1:0]    readable_length;
  logic [olb_pkg::BYTE_W-1:0]   out_byte;

  modport source(output valid, answer_kind, readable_length, out_byte, input ready);
  modport sink(input valid, answer_kind, readable_length, out_byte, output ready);
endinterface

`default_nettype wire

### hdl/overwriting_line_log_buffer_core.sv
// overwriting line log buffer: byte ring, tick prefix writer, line-aligned reader
//
// in_chan carries one request word per handshake (valid and ready high at a
// rising edge): put byte, put tick prefix, measure readable text, fetch byte.
// out_chan carries one answer word for measure and fetch; put operations
// give none. Requests are handled one at a time, in order.
// steps per request, from accept until ready rises again:
//   put byte    written at the accept edge
//   prefix      bit-serial binary to decimal conversion, then the digit
//               slots, then ']' and ' '
//   measure     one ring read per cycle through the single read port,
//               pipelined behind the newline check
//   fetch       ring read at the accept edge, answer loaded in the answer state
// answers sit in an output register; a stalled receiver holds the block in
// its answer state, and ready stays low until the answer register frees up.
// after reset the init state writes a newline at ring entry zero while ready
// stays low; other ring entries never reach an answer before they are written.
`default_nettype none

module overwriting_line_log_buffer_core #(
  parameter int unsigned RING_BYTES = olb_pkg::RING_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  olb_in_if.sink     in_chan,
  olb_out_if.source  out_chan
);
  import olb_pkg::*;

  localparam int IW = $clog2(RING_BYTES);           // ring index
  localparam int LW = $clog2(RING_BYTES + 1);       // byte counts up to the ring size
  localparam int PW = LW + 1;                       // append position sum
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int OW = (LW > OFFSET_W) ? LW : OFFSET_W;
  localparam int SW = ((IW > OFFSET_W) ? IW : OFFSET_W) + 1;

  localparam logic [IW-1:0] LAST_IDX = IW'(RING_BYTES - 1);
  localparam logic [PW-1:0] RING_P   = PW'(RING_BYTES);
  localparam logic [SW-1:0] RING_S   = SW'(RING_BYTES);
  localparam logic [LW-1:0] RING_L   = LW'(RING_BYTES);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + IW'(1);
  endfunction

  // control state
  st_t                 state_r, state_nxt;
  logic [IW-1:0]       oldest_r, oldest_nxt;
  logic [LW-1:0]       fill_r, fill_nxt;
  logic [IW-1:0]       saved_start_r, saved_start_nxt;
  logic [LW-1:0]       saved_len_r, saved_len_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working registers
  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [IW-1:0]       scan_addr_r, scan_addr_nxt;
  logic [LW-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [IW-1:0]       chk_addr_r, chk_addr_nxt;
  logic [LW-1:0]       chk_cnt_r, chk_cnt_nxt;
  logic [TICK_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_left_r, dig_left_nxt;
  logic                started_r, started_nxt;
  logic                res_kind_r, res_kind_nxt;
  logic                hit_r, hit_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;

  // ring memory, one write and one read port
  logic [BYTE_W-1:0]   ring_mem [RING_BYTES];
  logic [BYTE_W-1:0]   mem_q;
  logic                wr_en, rd_en;
  logic [IW-1:0]       wr_addr, rd_addr;
  logic [BYTE_W-1:0]   wr_data;

  // shared append path
  logic                app_en;
  logic [BYTE_W-1:0]   app_data;
  logic [PW-1:0]       app_sum;
  logic [IW-1:0]       app_pos;

  logic                in_acc;
  op_t                 in_op;
  logic                out_free;

  // measure and fetch helpers
  logic                scan_hit, scan_end;
  logic [IW-1:0]       m_start;
  logic [LW-1:0]       m_len;
  logic [CW-1:0]       m_len_ext, lim_ext, m_cap;
  logic [SW-1:0]       f_sum;
  logic [IW-1:0]       f_addr;
  logic                f_hit;

  // decimal conversion helpers
  logic [BCD_W-1:0]    bcd_adj;
  logic [DIGIT_W-1:0]  top_digit;
  logic                dig_emit;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_op         = op_t'(in_chan.operation);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid           = out_valid_r;
  assign out_chan.answer_kind     = out_kind_r;
  assign out_chan.readable_length = out_len_r;
  assign out_chan.out_byte        = out_byte_r;

  // next write position, wrapping past the ring end
  assign app_sum = PW'(oldest_r) + PW'(fill_r);
  assign app_pos = IW'((app_sum >= RING_P) ? app_sum - RING_P : app_sum);

  // fetch address relative to the saved start
  assign f_sum  = SW'(saved_start_r) + SW'(in_chan.byte_offset);
  assign f_addr = IW'((f_sum >= RING_S) ? f_sum - RING_S : f_sum);
  assign f_hit  = OW'(in_chan.byte_offset) < OW'(saved_len_r);

  // newline check looks at the read data in the cycle after the read issue
  assign scan_hit = chk_vld_r && (mem_q == CH_NEWLINE);
  assign scan_end = chk_vld_r && (scan_hit || (chk_cnt_r == fill_r - LW'(1)));
  assign m_start  = scan_hit ? wrap_inc(chk_addr_r) : oldest_r;
  assign m_len    = scan_hit ? fill_r - chk_cnt_r - LW'(1) : fill_r;

  // cap at limit minus one, zero limit gives zero
  assign m_len_ext = CW'(m_len);
  assign lim_ext   = CW'(limit_r);
  always_comb begin
    if (limit_r == '0) begin
      m_cap = '0;
    end else if (m_len_ext > lim_ext - CW'(1)) begin
      m_cap = lim_ext - CW'(1);
    end else begin
      m_cap = m_len_ext;
    end
  end

  // one double-dabble step: add three to digits of five or more
  always_comb begin
    logic [DIGIT_W-1:0] dig;
    for (int d = 0; d < DIGITS; d++) begin
      dig = bcd_r[d*DIGIT_W +: DIGIT_W];
      bcd_adj[d*DIGIT_W +: DIGIT_W] = (dig >= DIGIT_W'(5)) ? dig + DIGIT_W'(3) : dig;
    end
  end

  // leading zeros are skipped, the last digit always goes out
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];
  assign dig_emit  = started_r || (top_digit != '0) || (dig_left_r == DIG_CNT_W'(1));

  // memory ports
  assign wr_en   = app_en || (state_r == ST_INIT);
  assign wr_addr = (state_r == ST_INIT) ? '0 : app_pos;
  assign wr_data = (state_r == ST_INIT) ? CH_NEWLINE : app_data;
  assign rd_en   = (state_r == ST_SCAN) || (in_acc && (in_op == OP_FETCH));
  assign rd_addr = (state_r == ST_SCAN) ? scan_addr_r : f_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= ring_mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_PREFIX:  state_nxt = ST_CONV;
            OP_MEASURE: state_nxt = ST_SCAN;
            OP_FETCH:   state_nxt = ST_RESP;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == BIT_CNT_W'(TICK_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dig_left_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: state_nxt = ST_SPACE;
      ST_SPACE: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    oldest_nxt      = oldest_r;
    fill_nxt        = fill_r;
    saved_start_nxt = saved_start_r;
    saved_len_nxt   = saved_len_r;
    chk_vld_nxt     = chk_vld_r;
    limit_nxt       = limit_r;
    scan_addr_nxt   = scan_addr_r;
    scan_cnt_nxt    = scan_cnt_r;
    chk_addr_nxt    = chk_addr_r;
    chk_cnt_nxt     = chk_cnt_r;
    bin_nxt         = bin_r;
    bcd_nxt         = bcd_r;
    bit_cnt_nxt     = bit_cnt_r;
    dig_left_nxt    = dig_left_r;
    started_nxt     = started_r;
    res_kind_nxt    = res_kind_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_kind_nxt    = out_kind_r;
    out_len_nxt     = out_len_r;
    out_byte_nxt    = out_byte_r;
    app_en          = 1'b0;
    app_data        = in_chan.data_byte;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_PUT: begin
              app_en = 1'b1;
            end
            OP_PREFIX: begin
              app_en      = 1'b1;
              app_data    = CH_OPEN;
              bin_nxt     = in_chan.tick_count;
              bcd_nxt     = '0;
              bit_cnt_nxt = '0;
            end
            OP_MEASURE: begin
              limit_nxt     = in_chan.read_limit;
              scan_addr_nxt = oldest_r;
              scan_cnt_nxt  = '0;
              chk_vld_nxt   = 1'b0;
              res_kind_nxt  = KIND_LENGTH;
            end
            OP_FETCH: begin
              res_kind_nxt = KIND_BYTE;
              hit_nxt      = f_hit;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        bcd_nxt      = {bcd_adj[BCD_W-2:0], bin_r[TICK_W-1]};
        bin_nxt      = {bin_r[TICK_W-2:0], 1'b0};
        bit_cnt_nxt  = bit_cnt_r + BIT_CNT_W'(1);
        dig_left_nxt = DIG_CNT_W'(DIGITS);
        started_nxt  = 1'b0;
      end
      ST_EMIT: begin
        if (dig_emit) begin
          app_en      = 1'b1;
          app_data    = CH_ZERO + BYTE_W'(top_digit);
          started_nxt = 1'b1;
        end
        bcd_nxt      = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dig_left_nxt = dig_left_r - DIG_CNT_W'(1);
      end
      ST_CLOSE: begin
        app_en   = 1'b1;
        app_data = CH_CLOSE;
      end
      ST_SPACE: begin
        app_en   = 1'b1;
        app_data = CH_SPACE;
      end
      ST_SCAN: begin
        scan_addr_nxt = wrap_inc(scan_addr_r);
        scan_cnt_nxt  = scan_cnt_r + LW'(1);
        chk_vld_nxt   = 1'b1;
        chk_addr_nxt  = scan_addr_r;
        chk_cnt_nxt   = scan_cnt_r;
        if (scan_end) begin
          chk_vld_nxt     = 1'b0;
          saved_start_nxt = m_start;
          saved_len_nxt   = LW'(m_cap);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_len_nxt   = (res_kind_r == KIND_LENGTH) ? LEN_W'(saved_len_r) : '0;
          out_byte_nxt  = ((res_kind_r == KIND_BYTE) && hit_r) ? mem_q : '0;
        end
      end
      default: ;
    endcase

    // a full ring drops its oldest byte
    if (app_en) begin
      if (fill_r == RING_L) begin
        oldest_nxt = wrap_inc(oldest_r);
      end else begin
        fill_nxt = fill_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      oldest_r      <= '0;
      fill_r        <= LW'(1);
      saved_start_r <= '0;
      saved_len_r   <= '0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      oldest_r      <= oldest_nxt;
      fill_r        <= fill_nxt;
      saved_start_r <= saved_start_nxt;
      saved_len_r   <= saved_len_nxt;
      chk_vld_r     <= chk_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r     <= limit_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    chk_addr_r  <= chk_addr_nxt;
    chk_cnt_r   <= chk_cnt_nxt;
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    dig_left_r  <= dig_left_nxt;
    started_r   <= started_nxt;
    res_kind_r  <= res_kind_nxt;
    hit_r       <= hit_nxt;
    out_kind_r  <= out_kind_nxt;
    out_len_r   <= out_len_nxt;
    out_byte_r  <= out_byte_nxt;
  end

endmodule

`default_nettype wire
